@@ rtl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants shared by the bitmap set unit and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int COUNT_W = 13;
  localparam int VALUE_W = 12;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'h1fff;
  localparam logic [COUNT_W-1:0] MAXV_RESET = 13'd4096;

  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_CLEAR    = 3'd1;
  localparam logic [2:0] OP_TEST     = 3'd2;
  localparam logic [2:0] OP_FILL     = 3'd3;
  localparam logic [2:0] OP_WIPE     = 3'd4;
  localparam logic [2:0] OP_FIND_MIN = 3'd5;
  localparam logic [2:0] OP_FIND_MAX = 3'd6;

  typedef struct packed {
    logic [2:0]         operation;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               flag;
    logic [COUNT_W-1:0] member_count;
    logic [VALUE_W-1:0] found_value;
    logic               error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_SWEEP,
    ST_SCAN_INIT,
    ST_SCAN
  } state_t;

endpackage

`default_nettype wire

@@ rtl/bitmap_set_with_count_unit.sv @@
// ----------------------------------------------------------------------------
// bitmap_set_with_count_unit
// Set of small integers kept as a bitmap of words in one RAM, plus a count.
// Insert, clear, test, fill, wipe, find lowest and find highest member.
// ----------------------------------------------------------------------------
// Insert, clear, test: word read, then modify and write.
// Range errors, unused code, find on an empty set: answered from idle, no RAM access.
// Fill, wipe: one RAM word written per cycle.
// Find: one RAM word read per cycle, early exit.
// Result strobed in the cycle after the last busy cycle; receiver cannot stall.
// Reset runs a clearing pass over all RAM words with busy high.
`default_nettype none

module bitmap_set_with_count_unit
  import bsc_pkg::*;
#(
  parameter int CAPACITY  = 4096,
  parameter int WORD_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           in_payload,
  output logic                    out_strobe,
  output out_item_t               out_payload,
  input  wire logic               cfg_we,
  input  wire logic [COUNT_W-1:0] cfg_wdata
);

  localparam int NumWords   = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int JW         = $clog2(WORD_BITS);
  localparam int BW         = COUNT_W + 1;
  localparam int RecipShift = 24;
  localparam int Recip      = ((1 << RecipShift) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW         = RecipShift + COUNT_W;
  localparam int CapClip    = (CAPACITY > 8191) ? 8191 : CAPACITY;
  localparam logic [AW-1:0]        LastAddr = AW'(NumWords - 1);
  localparam logic [COUNT_W-1:0]   CapW     = COUNT_W'(CapClip);
  localparam logic [WORD_BITS-1:0] AllOnes  = '1;

  state_t                 state_r, state_nxt;
  logic [COUNT_W-1:0]     max_values_r;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic [2:0]             op_r, op_nxt;
  logic [VALUE_W-1:0]     val_r, val_nxt;
  logic [AW-1:0]          q_r, q_nxt;
  logic                   dir_r, dir_nxt;
  logic [AW-1:0]          last_r, last_nxt;
  logic [AW-1:0]          iss_addr_r, iss_addr_nxt;
  logic                   iss_done_r, iss_done_nxt;
  logic [BW-1:0]          iss_base_r, iss_base_nxt;
  logic                   chk_valid_r, chk_valid_nxt;
  logic [BW-1:0]          chk_base_r, chk_base_nxt;
  logic                   chk_last_r, chk_last_nxt;
  logic                   sweep_fill_r, sweep_fill_nxt;
  logic                   sweep_emit_r, sweep_emit_nxt;
  out_item_t              out_r, out_nxt;
  logic                   out_strobe_r, out_strobe_nxt;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]   ram_wdata, ram_rdata;

  logic                   accept;
  logic                   in_range;
  logic                   is_find;
  logic [COUNT_W-1:0]     lim;
  logic [COUNT_W-1:0]     div_in;
  logic [PW-1:0]          prod;
  logic [AW-1:0]          q_in;
  logic                   find_empty;
  logic [31:0]            rem_full;
  logic [JW-1:0]          bidx;
  logic [WORD_BITS-1:0]   bmask;
  logic                   old_bit;
  logic [BW-1:0]          span;
  logic [WORD_BITS-1:0]   masked;
  logic [JW-1:0]          pick;
  logic                   hit;
  logic                   sweep_last;
  logic                   iss_last;

  bsc_word_ram #(
    .DEPTH (NumWords),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign lim      = (max_values_r < CapW) ? max_values_r : CapW;
  assign is_find  = (in_payload.operation == OP_FIND_MIN) ||
                    (in_payload.operation == OP_FIND_MAX);
  assign in_range = ({1'b0, in_payload.value} < max_values_r) &&
                    (32'(in_payload.value) < CAPACITY);
  assign find_empty = (count_r == '0) || (lim == '0);

  assign div_in = is_find ? (lim - COUNT_W'(1)) : {1'b0, in_payload.value};
  assign prod   = PW'(div_in) * PW'(Recip);
  assign q_in   = prod[RecipShift +: AW];

  assign rem_full = 32'(val_r) - 32'(q_r) * WORD_BITS;
  assign bidx     = rem_full[JW-1:0];
  assign bmask    = WORD_BITS'(1) << bidx;
  assign old_bit  = |(ram_rdata & bmask);

  assign span       = BW'(lim) - chk_base_r;
  assign sweep_last = (iss_addr_r == LastAddr);
  assign iss_last   = dir_r ? (iss_addr_r == '0) : (iss_addr_r == last_r);

  always_comb begin
    masked = '0;
    pick   = '0;
    hit    = 1'b0;
    for (int j = 0; j < WORD_BITS; j++) begin
      masked[j] = ram_rdata[j] && (BW'(j) < span);
      if (masked[j] && (!hit || dir_r)) begin
        pick = JW'(j);
        hit  = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_payload.operation) inside
            OP_INSERT, OP_CLEAR, OP_TEST: begin
              if (in_range) begin
                state_nxt = ST_RMW;
              end
            end
            OP_FILL, OP_WIPE: begin
              state_nxt = ST_SWEEP;
            end
            OP_FIND_MIN, OP_FIND_MAX: begin
              if (!find_empty) begin
                state_nxt = ST_SCAN_INIT;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RMW: begin
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN_INIT: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (chk_valid_r && (hit || chk_last_r)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    q_nxt          = q_r;
    dir_nxt        = dir_r;
    last_nxt       = last_r;
    iss_addr_nxt   = iss_addr_r;
    iss_done_nxt   = iss_done_r;
    iss_base_nxt   = iss_base_r;
    chk_valid_nxt  = 1'b0;
    chk_base_nxt   = chk_base_r;
    chk_last_nxt   = chk_last_r;
    sweep_fill_nxt = sweep_fill_r;
    sweep_emit_nxt = sweep_emit_r;
    out_nxt        = out_r;
    out_strobe_nxt = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = iss_addr_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = iss_addr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_payload.operation) inside
            OP_INSERT, OP_CLEAR, OP_TEST: begin
              if (in_range) begin
                ram_re    = 1'b1;
                ram_raddr = q_in;
                op_nxt    = in_payload.operation;
                val_nxt   = in_payload.value;
                q_nxt     = q_in;
              end else begin
                out_strobe_nxt = 1'b1;
                out_nxt        = '{flag: 1'b0, member_count: count_r,
                                   found_value: '0, error: 1'b1};
              end
            end
            OP_FILL, OP_WIPE: begin
              sweep_fill_nxt = (in_payload.operation == OP_FILL);
              sweep_emit_nxt = 1'b1;
              iss_addr_nxt   = '0;
            end
            OP_FIND_MIN, OP_FIND_MAX: begin
              if (find_empty) begin
                out_strobe_nxt = 1'b1;
                out_nxt        = '{flag: 1'b0, member_count: count_r,
                                   found_value: '0, error: 1'b1};
              end else begin
                dir_nxt  = (in_payload.operation == OP_FIND_MAX);
                last_nxt = q_in;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
              out_nxt        = '{flag: 1'b0, member_count: count_r,
                                 found_value: '0, error: 1'b0};
            end
          endcase
        end
      end

      ST_RMW: begin
        ram_waddr = q_r;
        case (op_r)
          OP_INSERT: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | bmask;
            if (!old_bit && (count_r != COUNT_MAX)) begin
              count_nxt = count_r + COUNT_W'(1);
            end
          end
          OP_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~bmask;
            if (old_bit && (count_r != '0)) begin
              count_nxt = count_r - COUNT_W'(1);
            end
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
        out_strobe_nxt = 1'b1;
        out_nxt        = '{flag: (op_r == OP_INSERT) ? !old_bit : old_bit,
                           member_count: count_nxt,
                           found_value: '0, error: 1'b0};
      end

      ST_SWEEP: begin
        ram_we       = 1'b1;
        ram_wdata    = sweep_fill_r ? AllOnes : '0;
        iss_addr_nxt = iss_addr_r + AW'(1);
        if (sweep_last) begin
          iss_addr_nxt = '0;
          if (sweep_emit_r) begin
            count_nxt      = sweep_fill_r ? max_values_r : '0;
            out_strobe_nxt = 1'b1;
            out_nxt        = '{flag: 1'b0, member_count: count_nxt,
                               found_value: '0, error: 1'b0};
          end
        end
      end

      ST_SCAN_INIT: begin
        iss_addr_nxt = dir_r ? last_r : '0;
        iss_base_nxt = dir_r ? BW'(32'(last_r) * WORD_BITS) : '0;
        iss_done_nxt = 1'b0;
      end

      ST_SCAN: begin
        if (!iss_done_r) begin
          ram_re        = 1'b1;
          ram_raddr     = iss_addr_r;
          chk_valid_nxt = 1'b1;
          chk_base_nxt  = iss_base_r;
          chk_last_nxt  = iss_last;
          iss_done_nxt  = iss_last;
          iss_addr_nxt  = dir_r ? (iss_addr_r - AW'(1)) : (iss_addr_r + AW'(1));
          iss_base_nxt  = dir_r ? (iss_base_r - BW'(WORD_BITS))
                                : (iss_base_r + BW'(WORD_BITS));
        end
        if (chk_valid_r && hit) begin
          out_strobe_nxt = 1'b1;
          out_nxt        = '{flag: 1'b0, member_count: count_r,
                             found_value: VALUE_W'(chk_base_r + BW'(pick)),
                             error: 1'b0};
        end else if (chk_valid_r && chk_last_r) begin
          out_strobe_nxt = 1'b1;
          out_nxt        = '{flag: 1'b0, member_count: count_r,
                             found_value: '0, error: 1'b1};
        end
      end

      default: begin
        out_strobe_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      max_values_r <= MAXV_RESET;
      count_r      <= '0;
      iss_addr_r   <= '0;
      iss_done_r   <= 1'b0;
      chk_valid_r  <= 1'b0;
      sweep_fill_r <= 1'b0;
      sweep_emit_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      iss_addr_r   <= iss_addr_nxt;
      iss_done_r   <= iss_done_nxt;
      chk_valid_r  <= chk_valid_nxt;
      sweep_fill_r <= sweep_fill_nxt;
      sweep_emit_r <= sweep_emit_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        max_values_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    q_r        <= q_nxt;
    dir_r      <= dir_nxt;
    last_r     <= last_nxt;
    iss_base_r <= iss_base_nxt;
    chk_base_r <= chk_base_nxt;
    chk_last_r <= chk_last_nxt;
    out_r      <= out_nxt;
  end

  assign out_strobe  = out_strobe_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire

@@ rtl/bsc_word_ram.sv @@
// ----------------------------------------------------------------------------
// bsc_word_ram
// Single-clock word RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_word_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/bsc_checker.sv @@
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the bitmap set unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_checker
  import bsc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_strobe,
  input wire out_item_t out_payload
);

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted beat neither started work nor returned a result");

  a_strobe_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy || start))
    else $error("result beat without preceding work");

  a_error_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_payload.error) |-> !out_payload.flag)
    else $error("error result carries flag");

  a_error_no_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_payload.error) |-> (out_payload.found_value == '0))
    else $error("error result carries a found value");

endmodule

bind bitmap_set_with_count_unit bsc_checker u_bsc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_strobe  (out_strobe),
  .out_payload (out_payload)
);

`default_nettype wire
